// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the escape-count block.
// No dependencies; the checker takes this header in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/mec_pkg.sv =====
// Package for the Mandelbrot escape-count block: field widths and default parameters.
// No dependencies; used by the core and its checker.
package mec_pkg;

    // Width of one coordinate and of the result field.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    // Default sizing of the iteration loop and the fixed-point format.
    localparam int DEF_MAX_ITERATIONS = 256;
    localparam int DEF_FRACTION_BITS  = 22;

endpackage

// ===== hw/rtl/mandelbrot_escape_count_core.sv =====
// Mandelbrot escape-time counter for one point in signed fixed point.
// Depends on mec_pkg for widths and default parameters.

// One item is a point c; the block iterates z = z*z + c from z = c on a single shared
// 32 x 32 signed multiplier and returns one count per item. Each iteration is made of
// three multiplier passes plus the update, and an item holds the core until its count
// is handed over. The input is ready only while the core is idle; the result sits in
// an output register, so the next item is taken while a count still waits to be read,
// and a finished count waits in the core if the register is full.
module mandelbrot_escape_count_core #(
    parameter int MAX_ITERATIONS = mec_pkg::DEF_MAX_ITERATIONS,
    parameter int FRACTION_BITS  = mec_pkg::DEF_FRACTION_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [mec_pkg::DATA_W-1:0]  i_c_real,
    input  logic signed [mec_pkg::DATA_W-1:0]  i_c_imag,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic        [mec_pkg::COUNT_W-1:0] o_escape_count
);

    localparam int DW    = mec_pkg::DATA_W;
    localparam int CNT_W = $clog2(MAX_ITERATIONS);

    // Escape threshold 4.0 in the chosen format.
    localparam logic signed [DW-1:0] LIMIT = DW'(4) <<< FRACTION_BITS;

    // Count of completed updates at which the last update is being made.
    localparam logic [CNT_W-1:0] LAST_DONE = CNT_W'(MAX_ITERATIONS - 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RR,
        S_II,
        S_CHK,
        S_UPD,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic signed [DW-1:0]   r_cr;
    logic signed [DW-1:0]   r_ci;
    logic signed [DW-1:0]   r_zr;
    logic signed [DW-1:0]   r_zi;
    logic signed [DW-1:0]   r_prod;
    logic signed [DW-1:0]   r_rr;
    logic signed [DW-1:0]   r_ii;
    logic        [CNT_W-1:0] r_done;
    logic        [mec_pkg::COUNT_W-1:0] r_result;
    logic                   r_out_valid;
    logic        [mec_pkg::COUNT_W-1:0] r_out_count;

    logic signed [DW-1:0]   w_mul_a;
    logic signed [DW-1:0]   w_mul_b;
    logic signed [2*DW-1:0] w_mul_full;
    logic signed [DW-1:0]   n_prod;
    logic signed [DW-1:0]   w_mag;
    logic                   w_escape;
    logic signed [DW-1:0]   n_zr;
    logic signed [DW-1:0]   n_zi;
    logic        [8:0]      w_count_ext;

    // Operand selection for the shared multiplier, one product per state.
    always_comb begin
        unique case (r_state)
            S_RR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            S_II: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zi;
                w_mul_b = r_zr;
            end
        endcase
    end

    // Full signed product; the scaled middle word is registered.
    assign w_mul_full = w_mul_a * w_mul_b;
    assign n_prod     = w_mul_full[FRACTION_BITS+DW-1:FRACTION_BITS];

    // Squared magnitude wraps at the data width and is compared as signed.
    assign w_mag    = r_rr + r_prod;
    assign w_escape = w_mag > LIMIT;

    // Next value of z, made from the squares and the cross product.
    assign n_zr = r_rr - r_ii + r_cr;
    assign n_zi = r_prod + r_prod + r_ci;

    // Result is one more than the completed updates, kept to the field width.
    assign w_count_ext = 9'(r_done) + 9'd1;

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The hand-over state refills the register itself.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cr    <= i_c_real;
                        r_ci    <= i_c_imag;
                        r_zr    <= i_c_real;
                        r_zi    <= i_c_imag;
                        r_done  <= '0;
                        r_state <= S_RR;
                    end
                end
                S_RR: begin
                    r_state <= S_II;
                end
                S_II: begin
                    r_rr    <= r_prod;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_ii <= r_prod;
                    if (w_escape) begin
                        r_result <= w_count_ext[mec_pkg::COUNT_W-1:0];
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_zr   <= n_zr;
                    r_zi   <= n_zi;
                    r_done <= r_done + 1'b1;
                    if (r_done == LAST_DONE) begin
                        r_result <= w_count_ext[mec_pkg::COUNT_W-1:0] + 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_RR;
                    end
                end
                S_DONE: begin
                    // Hand the count over once the output register is free.
                    if (!r_out_valid || i_ready) begin
                        r_out_count <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_escape_count = r_out_count;

endmodule

// ===== hw/rtl/mec_checker.sv =====
// Port-level checker for the Mandelbrot escape-count core, bound into the core module.
// Depends on mec_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module mec_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic        [mec_pkg::COUNT_W-1:0] o_escape_count
);

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_valid && o_ready;
    assign w_out_stall = o_valid && !i_ready;

    // A waiting result stays offered and unchanged.
    `MEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_valid)
    `MEC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_stall, $stable(o_escape_count))

    // After an item is taken the core stays busy for at least one full iteration check.
    `MEC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, (!o_ready) [*3])

    // The core is never ready for an item in the cycle right after it took one.
    `MEC_ASSERT_IMPLY(a_no_double_take, i_clk, i_rst_n, $past(w_in_acc), !o_ready)

endmodule

bind mandelbrot_escape_count_core mec_checker u_mec_checker (.*);
